FILE: design/pdad_pkg.sv
// Shared types, constants and helpers of the planar dual-arm dynamics block.
package pdad_pkg;

	localparam int SIN_W = 17;
	localparam int COEF_W = 31;
	localparam int NUM_LOOKUPS = 7;
	localparam int NUM_WPROD = 8;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;

	typedef enum logic [2:0] {
		REG_BASE_INERTIA = 3'd0,
		REG_ARM_INERTIA = 3'd1,
		REG_COS_COUPLING = 3'd2,
		REG_SIN_COUPLING = 3'd3,
		REG_CENTER_GRAV = 3'd4,
		REG_ARM_GRAV = 3'd5,
		REG_CENTER_FRIC = 3'd6,
		REG_ARM_FRIC = 3'd7
	} reg_idx_t;

	function automatic logic [31:0] sat32(input logic signed [55:0] v);
		if (v > 56'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -56'sd2147483648) begin
			return 32'h8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

FILE: design/pdad_sine_rom.sv
// Quarter-wave sine table with a registered read port.
module pdad_sine_rom
	import pdad_pkg::*;
#(
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [$clog2(SINE_TABLE_ENTRIES + 1)-1:0]  addr,
	output logic [SIN_W-1:0]                           data
);

	typedef logic [SIN_W-1:0] tbl_t [0:SINE_TABLE_ENTRIES];

	function automatic tbl_t build_table();
		tbl_t t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
			x = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			term = ((term * x2) >> 30) / 64'd6;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 64'd210;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 64'd272;
			sum = sum + $signed(term);
			if (sum < 0) begin
				sum = 64'sd0;
			end
			sum = (sum + 64'sd8192) >>> 14;
			if (sum > 64'sd65536) begin
				sum = 64'sd65536;
			end
			t[i] = sum[SIN_W-1:0];
		end
		return t;
	endfunction

	localparam tbl_t TBL = build_table();

	always_ff @(posedge clk) begin
		if (en) begin
			data <= TBL[addr];
		end
	end

endmodule

FILE: design/planar_dual_arm_dynamics.sv
// One item is accepted per cycle while the output is not stalled.
// The seven table reads, coefficient products, split rate products, rounding and
// final sums with saturation each occupy one pipeline stage.
// A stalled valid output freezes all stages; in_stall follows it.
// Reset clears valid bits and loads the coefficient registers with defaults.
// Table contents are constant; no clearing pass is needed after reset.
module planar_dual_arm_dynamics
	import pdad_pkg::*;
#(
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] center_angle,
	input  logic signed [15:0] left_angle,
	input  logic signed [15:0] right_angle,
	input  logic signed [15:0] center_rate,
	input  logic signed [15:0] left_rate,
	input  logic signed [15:0] right_rate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] inertia_00,
	output logic signed [31:0] inertia_01,
	output logic signed [31:0] inertia_02,
	output logic signed [31:0] inertia_11,
	output logic signed [31:0] bias_center,
	output logic signed [31:0] bias_left,
	output logic signed [31:0] bias_right
);

	localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);

	logic [COEF_W-1:0] base_q, arm_q, cc_q, sc_q, cg_q, ag_q, cf_q, af_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 31'd113515;
			arm_q <= 31'd8602;
			cc_q <= 31'd8192;
			sc_q <= 31'd1147;
			cg_q <= 31'd963379;
			ag_q <= 31'd80282;
			cf_q <= 31'd6554;
			af_q <= 31'd6554;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_BASE_INERTIA: base_q <= cfg_data;
				REG_ARM_INERTIA: arm_q <= cfg_data;
				REG_COS_COUPLING: cc_q <= cfg_data;
				REG_SIN_COUPLING: sc_q <= cfg_data;
				REG_CENTER_GRAV: cg_q <= cfg_data;
				REG_ARM_GRAV: ag_q <= cfg_data;
				REG_CENTER_FRIC: cf_q <= cfg_data;
				REG_ARM_FRIC: af_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign en = !(v_s5 && out_stall);
	assign in_stall = !en;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 0: table addresses, rate products, friction
	logic [15:0]       ang [NUM_LOOKUPS];
	logic [IW-1:0]     idx [NUM_LOOKUPS];
	logic              neg [NUM_LOOKUPS];
	logic [14:0]       rfold [NUM_LOOKUPS];
	logic [31:0]       iprod [NUM_LOOKUPS];

	assign ang[0] = left_angle;
	assign ang[1] = left_angle + QUARTER_TURN;
	assign ang[2] = right_angle;
	assign ang[3] = right_angle + QUARTER_TURN;
	assign ang[4] = center_angle;
	assign ang[5] = left_angle + center_angle;
	assign ang[6] = right_angle + center_angle;

	always_comb begin
		for (int k = 0; k < NUM_LOOKUPS; k++) begin
			rfold[k] = {1'b0, ang[k][13:0]};
			if (ang[k][14]) begin
				rfold[k] = 15'd16384 - rfold[k];
			end
			iprod[k] = {17'd0, rfold[k]} * 32'(SINE_TABLE_ENTRIES);
			idx[k] = iprod[k][14 +: IW];
			neg[k] = ang[k][15];
		end
	end

	logic signed [17:0] tl, tr;
	logic signed [33:0] wl_c, wr_c, wc_c;
	logic signed [47:0] fcp, flp, frp;
	logic signed [47:0] fcr, flr, frr;

	assign tl = {{2{left_rate[15]}}, left_rate} + {center_rate[15], center_rate, 1'b0};
	assign tr = {{2{right_rate[15]}}, right_rate} + {center_rate[15], center_rate, 1'b0};
	assign wl_c = 34'(left_rate) * 34'(tl);
	assign wr_c = 34'(right_rate) * 34'(tr);
	assign wc_c = 34'(center_rate) * 34'(center_rate);
	assign fcp = 48'($signed({1'b0, cf_q})) * 48'(center_rate);
	assign flp = 48'($signed({1'b0, af_q})) * 48'(left_rate);
	assign frp = 48'($signed({1'b0, af_q})) * 48'(right_rate);
	assign fcr = fcp + 48'sd128;
	assign flr = flp + 48'sd128;
	assign frr = frp + 48'sd128;

	logic [SIN_W-1:0]   rom_s1 [NUM_LOOKUPS];
	logic               neg_s1 [NUM_LOOKUPS];
	logic signed [33:0] wl_s1, wr_s1, wc_s1;
	logic signed [39:0] fc_s1, fl_s1, fr_s1;

	for (genvar g = 0; g < NUM_LOOKUPS; g++) begin : g_rom
		pdad_sine_rom #(
			.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
		) u_rom (
			.clk(clk),
			.en(en),
			.addr(idx[g]),
			.data(rom_s1[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_LOOKUPS; k++) begin
				neg_s1[k] <= neg[k];
			end
			wl_s1 <= wl_c;
			wr_s1 <= wr_c;
			wc_s1 <= wc_c;
			fc_s1 <= fcr[47:8];
			fl_s1 <= flr[47:8];
			fr_s1 <= frr[47:8];
		end
	end

	// stage 1: coefficient times sine, rounded
	function automatic logic signed [32:0] cmul(input logic [COEF_W-1:0] c,
			input logic signed [17:0] s);
		logic signed [49:0] p;
		p = 50'($signed({1'b0, c})) * 50'(s) + 50'sd32768;
		return p[48:16];
	endfunction

	logic signed [17:0] sn [NUM_LOOKUPS];

	always_comb begin
		for (int k = 0; k < NUM_LOOKUPS; k++) begin
			sn[k] = neg_s1[k] ? -$signed({1'b0, rom_s1[k]}) : $signed({1'b0, rom_s1[k]});
		end
	end

	logic signed [32:0] sc_sl_s2, sc_sr_s2, sc_cl_s2, sc_cr_s2;
	logic signed [32:0] cc_cl_s2, cc_cr_s2, cc_sl_s2, cc_sr_s2;
	logic signed [32:0] cg_s_s2, ag_l_s2, ag_r_s2;
	logic signed [33:0] wl_s2, wr_s2, wc_s2;
	logic signed [39:0] fc_s2, fl_s2, fr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sc_sl_s2 <= cmul(sc_q, sn[0]);
			sc_cl_s2 <= cmul(sc_q, sn[1]);
			sc_sr_s2 <= cmul(sc_q, sn[2]);
			sc_cr_s2 <= cmul(sc_q, sn[3]);
			cc_sl_s2 <= cmul(cc_q, sn[0]);
			cc_cl_s2 <= cmul(cc_q, sn[1]);
			cc_sr_s2 <= cmul(cc_q, sn[2]);
			cc_cr_s2 <= cmul(cc_q, sn[3]);
			cg_s_s2 <= cmul(cg_q, sn[4]);
			ag_l_s2 <= cmul(ag_q, sn[5]);
			ag_r_s2 <= cmul(ag_q, sn[6]);
			wl_s2 <= wl_s1;
			wr_s2 <= wr_s1;
			wc_s2 <= wc_s1;
			fc_s2 <= fc_s1;
			fl_s2 <= fl_s1;
			fr_s2 <= fr_s1;
		end
	end

	// stage 2: split products with the rate terms, linear sums
	logic signed [32:0] ma [NUM_WPROD];
	logic signed [33:0] mw [NUM_WPROD];

	assign ma[0] = sc_cl_s2;
	assign mw[0] = wl_s2;
	assign ma[1] = cc_sl_s2;
	assign mw[1] = wl_s2;
	assign ma[2] = cc_sr_s2;
	assign mw[2] = wr_s2;
	assign ma[3] = sc_cr_s2;
	assign mw[3] = wr_s2;
	assign ma[4] = cc_sl_s2;
	assign mw[4] = wc_s2;
	assign ma[5] = sc_cl_s2;
	assign mw[5] = wc_s2;
	assign ma[6] = cc_sr_s2;
	assign mw[6] = wc_s2;
	assign ma[7] = sc_cr_s2;
	assign mw[7] = wc_s2;

	logic signed [50:0] pplo_s3 [NUM_WPROD];
	logic signed [49:0] pphi_s3 [NUM_WPROD];
	logic signed [41:0] b00_s3, b01_s3, b02_s3, g0_s3, g1_s3, g2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_WPROD; k++) begin
				pplo_s3[k] <= 51'(ma[k]) * 51'($signed({1'b0, mw[k][16:0]}));
				pphi_s3[k] <= 50'(ma[k]) * 50'($signed(mw[k][33:17]));
			end
			b00_s3 <= 42'($signed({1'b0, base_q})) + 42'(sc_sl_s2) * 42'sd2
				- 42'(sc_sr_s2) * 42'sd2 + 42'(cc_cl_s2) * 42'sd2 + 42'(cc_cr_s2) * 42'sd2;
			b01_s3 <= 42'($signed({1'b0, arm_q})) + 42'(cc_cl_s2) + 42'(sc_sl_s2);
			b02_s3 <= 42'($signed({1'b0, arm_q})) + 42'(cc_cr_s2) - 42'(sc_sr_s2);
			g0_s3 <= 42'(fc_s2) + 42'(cg_s_s2) + 42'(ag_l_s2) + 42'(ag_r_s2);
			g1_s3 <= 42'(fl_s2) + 42'(ag_l_s2);
			g2_s3 <= 42'(fr_s2) + 42'(ag_r_s2);
		end
	end

	// stage 3: join partial products and round
	logic signed [67:0] full [NUM_WPROD];

	always_comb begin
		for (int k = 0; k < NUM_WPROD; k++) begin
			full[k] = (68'(pphi_s3[k]) <<< 17) + 68'(pplo_s3[k]) + 68'sd32768;
		end
	end

	logic signed [51:0] m_s4 [NUM_WPROD];
	logic signed [41:0] b00_s4, b01_s4, b02_s4, g0_s4, g1_s4, g2_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_WPROD; k++) begin
				m_s4[k] <= full[k][67:16];
			end
			b00_s4 <= b00_s3;
			b01_s4 <= b01_s3;
			b02_s4 <= b02_s3;
			g0_s4 <= g0_s3;
			g1_s4 <= g1_s3;
			g2_s4 <= g2_s3;
		end
	end

	// stage 4: final sums and saturation
	logic signed [55:0] n0, n1, n2;

	assign n0 = 56'(g0_s4) + 56'(m_s4[0]) - 56'(m_s4[1]) - 56'(m_s4[2]) - 56'(m_s4[3]);
	assign n1 = 56'(g1_s4) + 56'(m_s4[4]) - 56'(m_s4[5]);
	assign n2 = 56'(g2_s4) + 56'(m_s4[6]) + 56'(m_s4[7]);

	always_ff @(posedge clk) begin
		if (en) begin
			inertia_00 <= sat32(56'(b00_s4));
			inertia_01 <= sat32(56'(b01_s4));
			inertia_02 <= sat32(56'(b02_s4));
			inertia_11 <= {1'b0, arm_q};
			bias_center <= sat32(n0);
			bias_left <= sat32(n1);
			bias_right <= sat32(n2);
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bias_center) && $stable(inertia_00))
		else $error("stalled result changed");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && v_s4 |=> out_valid)
		else $error("valid bit lost in pipeline");

endmodule

FILE: verif/planar_dual_arm_dynamics_tb.sv
// Self-checking testbench for the planar dual-arm dynamics pipeline.
`timescale 1ns / 100ps

module planar_dual_arm_dynamics_tb
	import pdad_pkg::*;
();

	localparam int TABLE_N = 1024;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [15:0] ac, al, ar;
		logic signed [15:0] rc, rl, rr;
	} joint_state_t;

	typedef struct packed {
		logic signed [31:0] b00, b01, b02, b11, n0, n1, n2;
	} dynamics_t;

	class dynamics_scoreboard;
		longint coef[8];
		longint sine_tab[TABLE_N + 1];
		dynamics_t pending[$];
		int mismatches;

		function new();
			longint unsigned x, x2, term;
			longint sum;
			for (int i = 0; i <= TABLE_N; i++) begin
				x = (longint'(i) * HALF_PI_Q30) / TABLE_N;
				x2 = (x * x) >> 30;
				term = x;
				sum = x;
				for (int k = 1; k <= 8; k++) begin
					term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
					if (k % 2 == 1) sum -= term;
					else sum += term;
				end
				if (sum < 0) sum = 0;
				sum = (sum + 8192) >>> 14;
				if (sum > 65536) sum = 65536;
				sine_tab[i] = sum;
			end
			coef = '{113515, 8602, 8192, 1147, 963379, 80282, 6554, 6554};
			mismatches = 0;
		endfunction

		function longint sine(logic [15:0] a);
			int r, idx;
			r = a[13:0];
			if (a[14]) r = 16384 - r;
			idx = (r * TABLE_N) >> 14;
			return a[15] ? -sine_tab[idx] : sine_tab[idx];
		endfunction

		function longint rnd(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function logic signed [31:0] clamp(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		function void note(joint_state_t j);
			longint sl, cl, sr, cr, s_c, s_lc, s_rc;
			longint sc_sl, sc_sr, sc_cl, sc_cr, cc_cl, cc_cr, cc_sl, cc_sr;
			longint rc, rl, rr, wl, wr, wc, b00, b01, b02, n0, n1, n2;
			dynamics_t e;
			rc = j.rc; rl = j.rl; rr = j.rr;
			sl = sine(j.al); cl = sine(j.al + QUARTER_TURN);
			sr = sine(j.ar); cr = sine(j.ar + QUARTER_TURN);
			s_c = sine(j.ac);
			s_lc = sine(j.al + j.ac); s_rc = sine(j.ar + j.ac);
			sc_sl = rnd(coef[3] * sl, 16); sc_sr = rnd(coef[3] * sr, 16);
			sc_cl = rnd(coef[3] * cl, 16); sc_cr = rnd(coef[3] * cr, 16);
			cc_cl = rnd(coef[2] * cl, 16); cc_cr = rnd(coef[2] * cr, 16);
			cc_sl = rnd(coef[2] * sl, 16); cc_sr = rnd(coef[2] * sr, 16);
			wl = rl * rl + 2 * rl * rc;
			wr = rr * rr + 2 * rr * rc;
			wc = rc * rc;
			b00 = coef[0] + 2 * sc_sl - 2 * sc_sr + 2 * cc_cl + 2 * cc_cr;
			b01 = coef[1] + cc_cl + sc_sl;
			b02 = coef[1] + cc_cr - sc_sr;
			n0 = rnd(coef[6] * rc, 8) + rnd(coef[4] * s_c, 16) + rnd(coef[5] * s_lc, 16)
				+ rnd(coef[5] * s_rc, 16) + rnd(sc_cl * wl, 16) - rnd(cc_sl * wl, 16)
				- rnd(cc_sr * wr, 16) - rnd(sc_cr * wr, 16);
			n1 = rnd(coef[7] * rl, 8) + rnd(coef[5] * s_lc, 16)
				+ rnd(cc_sl * wc, 16) - rnd(sc_cl * wc, 16);
			n2 = rnd(coef[7] * rr, 8) + rnd(coef[5] * s_rc, 16)
				+ rnd(cc_sr * wc, 16) + rnd(sc_cr * wc, 16);
			e.b00 = clamp(b00); e.b01 = clamp(b01); e.b02 = clamp(b02);
			e.b11 = clamp(coef[1]);
			e.n0 = clamp(n0); e.n1 = clamp(n1); e.n2 = clamp(n2);
			pending.push_back(e);
		endfunction

		function void check(dynamics_t got);
			dynamics_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: exp %0d %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d %0d",
						$realtime, e.b00, e.b01, e.b02, e.b11, e.n0, e.n1, e.n2,
						got.b00, got.b01, got.b02, got.b11, got.n0, got.n1, got.n2);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [30:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [15:0] center_angle, left_angle, right_angle;
	logic signed [15:0] center_rate, left_rate, right_rate;
	logic signed [31:0] inertia_00, inertia_01, inertia_02, inertia_11;
	logic signed [31:0] bias_center, bias_left, bias_right;

	dynamics_scoreboard sb = new();
	int send_idle_pct, recv_idle_pct;
	bit hold_off_req;
	bit hold_done;
	int cycles;

	planar_dual_arm_dynamics dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[planar_dual_arm_dynamics] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		joint_state_t j;
		dynamics_t r;
		if (arst_n && in_valid && !in_stall) begin
			j.ac = center_angle; j.al = left_angle; j.ar = right_angle;
			j.rc = center_rate; j.rl = left_rate; j.rr = right_rate;
			sb.note(j);
		end
		if (arst_n && out_valid && !out_stall) begin
			r.b00 = inertia_00; r.b01 = inertia_01; r.b02 = inertia_02;
			r.b11 = inertia_11; r.n0 = bias_center; r.n1 = bias_left; r.n2 = bias_right;
			sb.check(r);
		end
	end

	// receiver: random stall, plus one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done = 1;
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic logic [15:0] pick16();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'($urandom_range(3) * 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(joint_state_t j);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		center_angle <= j.ac; left_angle <= j.al; right_angle <= j.ar;
		center_rate <= j.rc; left_rate <= j.rl; right_rate <= j.rr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(int n);
		joint_state_t j;
		repeat (n) begin
			j.ac = pick16(); j.al = pick16(); j.ar = pick16();
			j.rc = pick16(); j.rl = pick16(); j.rr = pick16();
			if ($urandom_range(3) == 0) begin
				j.rc = $signed(16'($urandom_range(1023))) - 16'sd512;
				j.rl = $signed(16'($urandom_range(1023))) - 16'sd512;
				j.rr = $signed(16'($urandom_range(1023))) - 16'sd512;
			end
			send_item(j);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [30:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.coef[idx] = val;
	endtask

	task automatic write_all(int mode);
		logic [30:0] v;
		for (int i = 0; i < 8; i++) begin
			case (mode)
				0: v = '0;
				1: v = '1;
				2: v = 31'($urandom_range(2000000));
				default: v = 31'($urandom);
			endcase
			write_reg(reg_idx_t'(i), v);
		end
		cfg_write <= 1'b0;
	endtask

	initial begin
		joint_state_t j;
		logic [15:0] dir_vals[6] = '{16'h0000, 16'h4000, 16'h8000, 16'h7fff, 16'hc000, 16'hffff};
		arst_n <= 1'b0;
		cfg_write <= 1'b0; cfg_index <= '0; cfg_data <= '0;
		in_valid <= 1'b0;
		center_angle <= '0; left_angle <= '0; right_angle <= '0;
		center_rate <= '0; left_rate <= '0; right_rate <= '0;
		send_idle_pct = 38; recv_idle_pct = 65;
		hold_off_req = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 6; i++) begin
			j.ac = dir_vals[i]; j.al = dir_vals[(i + 1) % 6]; j.ar = dir_vals[(i + 3) % 6];
			j.rc = dir_vals[(i + 2) % 6]; j.rl = dir_vals[(i + 4) % 6];
			j.rr = dir_vals[(i + 5) % 6];
			send_item(j);
		end
		j.ac = 16'h8000; j.al = 16'h8000; j.ar = 16'h8000;
		j.rc = 16'sh8000; j.rl = 16'sh8000; j.rr = 16'sh8000;
		send_item(j);
		j.rc = 16'sh7fff; j.rl = 16'sh8000; j.rr = 16'sh7fff;
		send_item(j);
		send_random(250);
		drain();

		write_all(1);
		hold_off_req = 1;
		send_random(250);
		drain();

		write_all(0);
		send_random(150);
		drain();

		send_idle_pct = 65; recv_idle_pct = 38;
		write_all(2);
		send_random(300);
		drain();

		write_all(3);
		send_random(200);
		drain();

		send_idle_pct = 0; recv_idle_pct = 0;
		write_all(2);
		send_random(300);
		drain();

		write_all(3);
		send_random(200);
		drain();

		if (sb.mismatches == 0) begin
			$display("[planar_dual_arm_dynamics] OK");
		end else begin
			$display("[planar_dual_arm_dynamics] ERROR");
		end
		$finish;
	end

endmodule
